// File: rtl/text_tab_expand_crlf_strip_defines.svh
// Assertion macros used by the checker file of the text cleaner.
`ifndef TEXT_TAB_EXPAND_CRLF_STRIP_DEFINES_SVH
`define TEXT_TAB_EXPAND_CRLF_STRIP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define TTECS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttecs assertion failed");

// Next-cycle implication, checked outside of reset.
`define TTECS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttecs assertion failed");

`endif

// File: rtl/ttecs_pkg.sv
// Shared constants and controller/datapath interface types for the text cleaner.
package ttecs_pkg;

   localparam logic [7:0] CHAR_CTRL_Z     = 8'h1A;
   localparam logic [6:0] CHAR_TAB        = 7'd9;
   localparam logic [6:0] CHAR_LF         = 7'd10;
   localparam logic [6:0] CHAR_CR         = 7'd13;
   localparam logic [6:0] CHAR_SPACE      = 7'h20;
   localparam logic [6:0] TAB_WIDTH_RESET = 7'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // a request is taken this cycle
      logic tab_step;  // load the next space of a running tab expansion
   } ttecs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;      // the offered request gives at least one result
      logic multi;     // the offered request is a tab that gives more than one space
      logic cnt_one;   // exactly one space of the running expansion is left
   } ttecs_status_type;

endpackage

// File: rtl/ttecs_ctrl.sv
// Controller: handshake control and the tab expansion sequencer.
module ttecs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output ttecs_pkg::ttecs_cmd_type    cmd,
   input  ttecs_pkg::ttecs_status_type status
);
   import ttecs_pkg::*;

   typedef enum logic {ST_RUN, ST_TAB} state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;

   // The output register can be loaded when empty or when its content leaves now.
   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_RUN: begin
            req_tready = slot_free;
            if (req_tvalid && slot_free) begin
               cmd.accept = 1'b1;
               if (status.emit) begin
                  out_valid_in = 1'b1;
                  if (status.multi) begin
                     state_in = ST_TAB;
                  end
               end
            end
         end
         ST_TAB: begin
            if (slot_free) begin
               cmd.tab_step = 1'b1;
               out_valid_in = 1'b1;
               if (status.cnt_one) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

// File: rtl/ttecs_dp.sv
// Datapath: stream state, tab width register, byte decode and output register.
module ttecs_dp #(
   parameter int MAX_TAB_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [6:0]                   csr_wdata,
   input  logic [7:0]                   req_char,
   input  logic                         req_new_file,
   input  ttecs_pkg::ttecs_cmd_type     cmd,
   output ttecs_pkg::ttecs_status_type  status,
   output logic [6:0]                   out_char,
   output logic                         out_last
);
   import ttecs_pkg::*;

   localparam int PW = (MAX_TAB_WIDTH > 1) ? $clog2(MAX_TAB_WIDTH) : 1;
   localparam int EW = $clog2(MAX_TAB_WIDTH + 1);
   localparam int CW = (EW > 7) ? EW : 7;

   logic [6:0]    tab_width_ff;
   logic [PW-1:0] phase_ff, phase_in;
   logic          cr_ff, cr_in;
   logic          stop_ff, stop_in;
   logic [PW-1:0] cnt_ff;
   logic [6:0]    out_char_ff;
   logic          out_last_ff;

   logic [CW-1:0] tw_ext;
   logic [EW-1:0] width;
   logic [PW-1:0] phase_nf;
   logic          cr_nf;
   logic          stop_nf;
   logic [PW-1:0] phase_cur;
   logic [EW-1:0] phase_inc;
   logic [EW-1:0] spaces;
   logic [6:0]    ch;
   logic          is_ctrl_z;
   logic          is_drop;
   logic          is_tab;
   logic          is_cr;
   logic [6:0]    first_char;
   logic          first_last;

   // Effective tab width: zero counts as one, larger values saturate.
   always_comb begin
      tw_ext = CW'(tab_width_ff);
      if (tw_ext == '0) begin
         width = EW'(1);
      end else if (tw_ext > CW'(MAX_TAB_WIDTH)) begin
         width = EW'(MAX_TAB_WIDTH);
      end else begin
         width = EW'(tw_ext);
      end
   end

   always_comb begin
      phase_nf  = req_new_file ? '0 : phase_ff;
      cr_nf     = req_new_file ? 1'b0 : cr_ff;
      stop_nf   = stop_ff && !req_new_file;
      phase_cur = (EW'(phase_nf) >= width) ? '0 : phase_nf;
      phase_inc = EW'(phase_cur) + EW'(1);
      spaces    = width - EW'(phase_cur);
      ch        = req_char[6:0];
      is_ctrl_z = (req_char == CHAR_CTRL_Z);
      is_drop   = cr_nf && (ch == CHAR_LF);
      is_tab    = (ch == CHAR_TAB);
      is_cr     = (ch == CHAR_CR);

      status.emit    = !stop_nf && !is_ctrl_z && !is_drop;
      status.multi   = is_tab && (spaces != EW'(1));
      status.cnt_one = (cnt_ff == PW'(1));

      if (is_tab) begin
         first_char = CHAR_SPACE;
         first_last = (spaces == EW'(1));
      end else if (is_cr) begin
         first_char = CHAR_LF;
         first_last = 1'b1;
      end else begin
         first_char = ch;
         first_last = 1'b1;
      end

      // A stopped stream leaves every state bit as it is.
      phase_in = phase_ff;
      cr_in    = cr_ff;
      stop_in  = stop_ff;
      if (!stop_nf) begin
         cr_in = 1'b0;
         if (is_ctrl_z) begin
            stop_in  = 1'b0 | 1'b1;
            phase_in = phase_nf;
         end else begin
            stop_in = 1'b0;
            if (is_drop) begin
               phase_in = phase_cur;
            end else if (is_tab) begin
               phase_in = '0;
            end else if (is_cr) begin
               phase_in = '0;
               cr_in    = 1'b1;
            end else begin
               phase_in = (phase_inc >= width) ? '0 : PW'(phase_inc);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff <= TAB_WIDTH_RESET;
         phase_ff     <= '0;
         cr_ff        <= 1'b0;
         stop_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            tab_width_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            phase_ff <= phase_in;
            cr_ff    <= cr_in;
            stop_ff  <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         out_char_ff <= first_char;
         out_last_ff <= first_last;
         cnt_ff      <= PW'(spaces - EW'(1));
      end else if (cmd.tab_step) begin
         out_char_ff <= CHAR_SPACE;
         out_last_ff <= (cnt_ff == PW'(1));
         cnt_ff      <= cnt_ff - PW'(1);
      end
   end

   assign out_char = out_char_ff;
   assign out_last = out_last_ff;

endmodule

// File: rtl/text_tab_expand_crlf_strip.sv
// Top level of the text cleaner: tab expansion and CR/LF normalization.
//
// Each request carries one raw byte and a new-file flag; the block returns
// seven-bit characters. A raw 0x1A stops the stream until a request with
// the new-file flag arrives. A tab becomes spaces up to the next tab stop
// (the column is tracked modulo the tab width), a CR becomes a single LF and
// swallows an LF that directly follows it, and every other byte is passed
// through with bit 7 cleared. Ordinary, dropped and ignored bytes are taken
// at one request per clock while the output side keeps up, because a
// registered output stage separates the two channels. A tab that yields n
// spaces holds off the request side until its last space is loaded: the
// first space is loaded when the request is taken, and a down counter in
// the datapath loads the other n-1 spaces one per cycle while the result
// side accepts them. The tab width register may be written only while the
// block is idle; zero acts as one and values above MAX_TAB_WIDTH saturate
// to it. No memory and no clearing pass after reset.
module text_tab_expand_crlf_strip #(
   parameter int MAX_TAB_WIDTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   // Configuration: tab_width.
   input  logic       csr_we,
   input  logic [6:0] csr_wdata,
   // Request channel.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] char_in
   input  logic       req_tuser,    // [0] new_file
   // Result channel.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] out_char, [7] zero fill
   output logic       rsp_tlast     // last
);
   import ttecs_pkg::*;

   ttecs_cmd_type    cmd;
   ttecs_status_type status;
   logic [6:0]       out_char;

   // The controller owns the handshakes and sequences tab expansion.
   ttecs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath keeps the column, the pending CR and the stop flag.
   ttecs_dp #(
      .MAX_TAB_WIDTH (MAX_TAB_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_char     (req_tdata),
      .req_new_file (req_tuser),
      .cmd          (cmd),
      .status       (status),
      .out_char     (out_char),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_char};

endmodule

// File: rtl/ttecs_checker.sv
// Port-level assertion checker for the text cleaner, bound to the top level.
`include "text_tab_expand_crlf_strip_defines.svh"

module ttecs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled result holds its value.
   `TTECS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Only spaces of a tab expansion can be followed by more results.
   `TTECS_ASSERT_NOW(a_mid_is_space, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata == 8'h20)

   // No request is taken while a tab expansion is still running.
   `TTECS_ASSERT_NOW(a_tab_blocks, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

   // Spaces of one tab follow each other without a gap.
   `TTECS_ASSERT_NEXT(a_tab_no_gap, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)

endmodule

bind text_tab_expand_crlf_strip ttecs_checker u_ttecs_checker (.*);
